// File: rtl/min_distance_point_acceptor_unit_macros.svh
// Assertion macros shared by the point acceptor RTL.
// Each macro expects signals named clk and arst_n in the enclosing module.
`ifndef MIN_DISTANCE_POINT_ACCEPTOR_UNIT_MACROS_SVH
`define MIN_DISTANCE_POINT_ACCEPTOR_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MDPA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MDPA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/mdpa_pkg.sv
// Package of the minimum-distance point acceptor: widths, codes and shared types.
// No dependencies.
`timescale 1ns / 1ps

package mdpa_pkg;

	// Defaults of the top-level parameters.
	localparam int MAX_POINTS_DEF = 1024;
	localparam int AXES_DEF       = 3;
	localparam int COORD_BITS_DEF = 16;

	// Fixed field widths.
	localparam int FIELD_W    = 16;
	localparam int DSQ_W      = 34;
	localparam int LIM_W      = 11;
	localparam int CNT_OUT_W  = 11;
	localparam int SLOT_W     = 10;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 34;

	typedef enum logic [1:0] {
		OP_SEED  = 2'd0,
		OP_TEST  = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_STORED    = 2'd0,
		ST_OOB       = 2'd1,
		ST_TOO_CLOSE = 2'd2,
		ST_LIMIT     = 2'd3
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LOW_X       = 3'd0,
		CFG_HIGH_X      = 3'd1,
		CFG_LOW_Y       = 3'd2,
		CFG_HIGH_Y      = 3'd3,
		CFG_LOW_Z       = 3'd4,
		CFG_HIGH_Z      = 3'd5,
		CFG_MIN_DIST_SQ = 3'd6,
		CFG_POINT_LIMIT = 3'd7
	} cfg_reg_t;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_CHECK,
		FSM_SCAN,
		FSM_FIN
	} fsm_t;

	// Register file contents as seen by the datapath.
	typedef struct packed {
		logic [2:0][FIELD_W-1:0] low_b;
		logic [2:0][FIELD_W-1:0] high_b;
		logic [DSQ_W-1:0]        min_dist_sq;
		logic [LIM_W-1:0]        point_limit;
	} cfg_regs_t;

	// Controller to distance unit.
	typedef struct packed {
		logic start;
		logic data_vld;
	} dist_ctl_t;

	// Distance unit to controller.
	typedef struct packed {
		logic busy;
		logic too_close;
	} dist_sts_t;

endpackage

// File: rtl/mdpa_point_if.sv
// Input channel of the point acceptor: one op and one point per word.
// Depends on mdpa_pkg.
`timescale 1ns / 1ps

interface mdpa_point_if import mdpa_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [1:0]                op;
	logic signed [FIELD_W-1:0] coord_x;
	logic signed [FIELD_W-1:0] coord_y;
	logic signed [FIELD_W-1:0] coord_z;

	modport source (output valid, op, coord_x, coord_y, coord_z, input ready);
	modport sink (input valid, op, coord_x, coord_y, coord_z, output ready);
endinterface

// File: rtl/mdpa_result_if.sv
// Result channel of the point acceptor: one status word per input word.
// Depends on mdpa_pkg.
`timescale 1ns / 1ps

interface mdpa_result_if import mdpa_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [1:0]           status;
	logic [CNT_OUT_W-1:0] point_count;
	logic [SLOT_W-1:0]    slot;

	modport source (output valid, status, point_count, slot, input ready);
	modport sink (input valid, status, point_count, slot, output ready);
endinterface

// File: rtl/mdpa_cfg_if.sv
// Configuration write channel of the point acceptor.
// Depends on mdpa_pkg.
`timescale 1ns / 1ps

interface mdpa_cfg_if import mdpa_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/mdpa_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module mdpa_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// File: rtl/mdpa_cfg_regs.sv
// Configuration register file: bounds, squared spacing and point limit.
// Depends on mdpa_pkg and mdpa_cfg_if.
`timescale 1ns / 1ps

module mdpa_cfg_regs import mdpa_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	mdpa_cfg_if.sink   cfg,
	output cfg_regs_t  regs
);
	cfg_regs_t regs_q;

	// Writes are always taken.
	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	// Register writes, decoded by index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.low_b       <= {3{16'h8000}};
			regs_q.high_b      <= {3{16'h7FFF}};
			regs_q.min_dist_sq <= '0;
			regs_q.point_limit <= LIM_W'(1024);
		end else if (cfg.valid) begin
			case (cfg_reg_t'(cfg.index))
				CFG_LOW_X:       regs_q.low_b[0]    <= cfg.data[FIELD_W-1:0];
				CFG_HIGH_X:      regs_q.high_b[0]   <= cfg.data[FIELD_W-1:0];
				CFG_LOW_Y:       regs_q.low_b[1]    <= cfg.data[FIELD_W-1:0];
				CFG_HIGH_Y:      regs_q.high_b[1]   <= cfg.data[FIELD_W-1:0];
				CFG_LOW_Z:       regs_q.low_b[2]    <= cfg.data[FIELD_W-1:0];
				CFG_HIGH_Z:      regs_q.high_b[2]   <= cfg.data[FIELD_W-1:0];
				CFG_MIN_DIST_SQ: regs_q.min_dist_sq <= cfg.data[DSQ_W-1:0];
				CFG_POINT_LIMIT: regs_q.point_limit <= cfg.data[LIM_W-1:0];
				default: begin
				end
			endcase
		end
	end
endmodule

// File: rtl/mdpa_dist_unit.sv
// Distance pipeline: squared distance of the candidate to each stored point
// read from the point RAM, compared with the squared spacing. Depends on mdpa_pkg.
`timescale 1ns / 1ps

module mdpa_dist_unit import mdpa_pkg::*; #(
	parameter int AXES       = AXES_DEF,
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  dist_ctl_t                           ctl,
	input  logic [AXES-1:0][COORD_BITS-1:0]     cand,
	input  logic [AXES*COORD_BITS-1:0]          rd_data,
	input  logic [DSQ_W-1:0]                    min_dist_sq,
	output dist_sts_t                           sts
);
	localparam int DIFF_W = COORD_BITS + 1;
	localparam int SQ_W   = 2 * DIFF_W;
	localparam int SUM_W  = SQ_W + 2;
	localparam int CMP_W  = (SUM_W > DSQ_W) ? SUM_W : DSQ_W;

	logic [AXES-1:0][SQ_W-1:0] diff_ext;
	logic [AXES-1:0][SQ_W-1:0] sq_s2;
	logic                      vld_s2;
	logic [SUM_W-1:0]          sum;
	logic                      close_q;

	// Per-axis difference, sign-extended to the square's width.
	always_comb begin
		for (int a = 0; a < AXES; a++) begin
			diff_ext[a] = SQ_W'($signed(DIFF_W'($signed(cand[a]))
				- DIFF_W'($signed(rd_data[a*COORD_BITS +: COORD_BITS]))));
		end
	end

	// Stage 2: one square per axis.
	always_ff @(posedge clk) begin
		for (int a = 0; a < AXES; a++) begin
			sq_s2[a] <= diff_ext[a] * diff_ext[a];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= ctl.data_vld;
		end
	end

	// Sum of squares over the axes.
	always_comb begin
		sum = '0;
		for (int a = 0; a < AXES; a++) begin
			sum = sum + SUM_W'(sq_s2[a]);
		end
	end

	// Sticky flag: any stored point strictly closer than the spacing.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			close_q <= 1'b0;
		end else if (ctl.start) begin
			close_q <= 1'b0;
		end else if (vld_s2 && (CMP_W'(sum) < CMP_W'(min_dist_sq))) begin
			close_q <= 1'b1;
		end
	end

	assign sts.busy      = vld_s2;
	assign sts.too_close = close_q;
endmodule

// File: rtl/min_distance_point_acceptor_unit.sv
// Top level of the minimum-distance point acceptor: controller, point counter
// and result register. Depends on mdpa_pkg, the channel interfaces, mdpa_ram,
// mdpa_cfg_regs, mdpa_dist_unit and the assertion macro header.
//
// Usage:
//   point  : input words (op, coord_x, coord_y, coord_z), valid/ready.
//   result : one word per input word (status, point_count, slot), valid/ready.
//   cfg    : register writes (index, data), always ready; write only while idle.
//   A test op reads every stored point once from the point RAM, one entry per
//   cycle through its single read port, before its result is loaded; a seed,
//   clear or undefined op, or a test that fails the bounds check, goes from
//   the check state straight to the finish state without a scan.
//   The next word is accepted in the cycle after the result is loaded.
//   Results go through an output register: a new word is accepted while the
//   previous result still waits, and the controller holds its finished
//   result until that register is free, so a stalled receiver stalls input.
//   Reset clears the point count, the controller and the registers; the point
//   RAM needs no clearing pass since only entries below the count are read.
//   Writes to the RAM happen only at the end of an item, after its scan has
//   drained, so reads and writes of one entry never overlap.
`timescale 1ns / 1ps
`include "min_distance_point_acceptor_unit_macros.svh"

module min_distance_point_acceptor_unit import mdpa_pkg::*; #(
	parameter int MAX_POINTS = MAX_POINTS_DEF,
	parameter int AXES       = AXES_DEF,
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input logic          clk,
	input logic          arst_n,
	mdpa_point_if.sink   point,
	mdpa_result_if.source result,
	mdpa_cfg_if.sink     cfg
);
	localparam int ADDR_W = $clog2(MAX_POINTS);
	localparam int CNT_W  = $clog2(MAX_POINTS + 1);
	localparam int LW     = ((CNT_W > LIM_W) ? CNT_W : LIM_W) + 1;
	localparam int IN_B   = (COORD_BITS < FIELD_W) ? COORD_BITS : FIELD_W;
	localparam int BW     = (COORD_BITS > FIELD_W) ? COORD_BITS : FIELD_W;
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_POINTS);
	localparam logic [LW-1:0]    LIM_MAX = LW'(MAX_POINTS);

	cfg_regs_t                     regs;
	fsm_t                          state_q, state_d;
	op_t                           op_q;
	logic [AXES-1:0][COORD_BITS-1:0] cand, cand_q;
	logic [2:0][FIELD_W-1:0]       fields;
	logic                          inb, inb_q;
	logic [CNT_W-1:0]              count_q, count_d;
	logic [CNT_W-1:0]              rd_idx_q;
	logic                          rd_en, rd_vld_s1;
	logic [AXES*COORD_BITS-1:0]    rd_data;
	logic                          ram_we;
	dist_ctl_t                     dist_ctl;
	dist_sts_t                     dist_sts;
	logic                          out_free, fin_go, accept;
	logic                          do_store, do_clear, full;
	status_t                       fin_status;
	logic [LW-1:0]                 lim_eff;
	logic                          res_vld_q;
	status_t                       res_status_q;
	logic [CNT_OUT_W-1:0]          res_count_q;
	logic [SLOT_W-1:0]             res_slot_q;

	mdpa_cfg_regs u_cfg_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	mdpa_ram #(
		.WIDTH (AXES * COORD_BITS),
		.DEPTH (MAX_POINTS)
	) u_point_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (count_q[ADDR_W-1:0]),
		.wdata (cand_q),
		.re    (rd_en),
		.raddr (rd_idx_q[ADDR_W-1:0]),
		.rdata (rd_data)
	);

	mdpa_dist_unit #(
		.AXES       (AXES),
		.COORD_BITS (COORD_BITS)
	) u_dist_unit (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (dist_ctl),
		.cand        (cand_q),
		.rd_data     (rd_data),
		.min_dist_sq (regs.min_dist_sq),
		.sts         (dist_sts)
	);

	// Input coordinates, sign-extended from their low bits.
	always_comb begin
		fields[0] = point.coord_x;
		fields[1] = point.coord_y;
		fields[2] = point.coord_z;
		for (int a = 0; a < AXES; a++) begin
			cand[a] = COORD_BITS'($signed(fields[a][IN_B-1:0]));
		end
	end

	// Inclusive per-axis bounds check of the latched point.
	always_comb begin
		inb = 1'b1;
		for (int a = 0; a < AXES; a++) begin
			if (($signed(BW'($signed(cand_q[a]))) < $signed(BW'($signed(regs.low_b[a]))))
				|| ($signed(BW'($signed(cand_q[a])))
				> $signed(BW'($signed(regs.high_b[a]))))) begin
				inb = 1'b0;
			end
		end
	end

	// Limit, capped at the store depth.
	always_comb begin
		lim_eff = (LW'(regs.point_limit) > LIM_MAX) ? LIM_MAX : LW'(regs.point_limit);
		full    = LW'(count_q) >= lim_eff;
	end

	// Outcome of the current item.
	always_comb begin
		do_store   = 1'b0;
		do_clear   = 1'b0;
		fin_status = ST_STORED;
		case (op_q)
			OP_CLEAR: do_clear = 1'b1;
			OP_SEED: begin
				if (full) begin
					fin_status = ST_LIMIT;
				end else begin
					do_store = 1'b1;
				end
			end
			OP_TEST: begin
				if (!inb_q) begin
					fin_status = ST_OOB;
				end else if (dist_sts.too_close) begin
					fin_status = ST_TOO_CLOSE;
				end else if (full) begin
					fin_status = ST_LIMIT;
				end else begin
					do_store = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			FSM_IDLE: begin
				if (point.valid) begin
					state_d = FSM_CHECK;
				end
			end
			FSM_CHECK: begin
				if (op_q == OP_TEST && inb) begin
					state_d = FSM_SCAN;
				end else begin
					state_d = FSM_FIN;
				end
			end
			FSM_SCAN: begin
				if (rd_idx_q == count_q && !rd_vld_s1 && !dist_sts.busy) begin
					state_d = FSM_FIN;
				end
			end
			FSM_FIN: begin
				if (out_free) begin
					state_d = FSM_IDLE;
				end
			end
			default: state_d = FSM_IDLE;
		endcase
	end

	// Controller outputs.
	always_comb begin
		out_free          = !res_vld_q || result.ready;
		point.ready       = (state_q == FSM_IDLE);
		accept            = point.valid && (state_q == FSM_IDLE);
		rd_en             = (state_q == FSM_SCAN) && (rd_idx_q != count_q);
		dist_ctl.start    = (state_q == FSM_CHECK);
		dist_ctl.data_vld = rd_vld_s1;
		fin_go            = (state_q == FSM_FIN) && out_free;
		ram_we            = fin_go && do_store;
		if (do_clear) begin
			count_d = '0;
		end else if (do_store) begin
			count_d = count_q + 1'b1;
		end else begin
			count_d = count_q;
		end
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= FSM_IDLE;
			count_q   <= '0;
			rd_idx_q  <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= rd_en;
			if (state_q == FSM_CHECK) begin
				rd_idx_q <= '0;
			end else if (rd_en) begin
				rd_idx_q <= rd_idx_q + 1'b1;
			end
			if (fin_go) begin
				count_q <= count_d;
			end
		end
	end

	// Latched item and bounds result.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= op_t'(point.op);
			cand_q <= cand;
		end
		if (state_q == FSM_CHECK) begin
			inb_q <= inb;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (fin_go) begin
			res_vld_q <= 1'b1;
		end else if (result.ready) begin
			res_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_go) begin
			res_status_q <= fin_status;
			res_count_q  <= CNT_OUT_W'(count_d);
			res_slot_q   <= do_store ? SLOT_W'(count_q) : '0;
		end
	end

	assign result.valid       = res_vld_q;
	assign result.status      = res_status_q;
	assign result.point_count = res_count_q;
	assign result.slot        = res_slot_q;

	// Checks on the controller and the store.
	`MDPA_ASSERT_NOW(a_read_written, rd_en, rd_idx_q < count_q, "read beyond stored points")
	`MDPA_ASSERT_NOW(a_write_room, ram_we, count_q < CNT_MAX, "store written when full")
	`MDPA_ASSERT_NEXT(a_count_step, fin_go && do_store, count_q == $past(count_q) + 1'b1,
		"point count did not advance on store")
	`MDPA_ASSERT_NOW(a_data_in_scan, rd_vld_s1, state_q == FSM_SCAN,
		"read data returned outside a scan")
endmodule

// File: tb/min_distance_point_acceptor_unit_tb.sv
// Self-checking testbench of the minimum-distance point acceptor: drives point words and
// register writes, predicts each result word and compares it field by field.
// Depends on mdpa_pkg, the three channel interfaces and min_distance_point_acceptor_unit.
`timescale 1ns / 1ps

module min_distance_point_acceptor_unit_tb;
	import mdpa_pkg::*;

	// Predicts the verdict of every accepted point word and checks result words in order.
	class acceptance_scoreboard;
		typedef struct packed {
			status_t               status;
			logic [CNT_OUT_W-1:0]  count;
			logic [SLOT_W-1:0]     slot;
		} verdict_t;

		logic signed [FIELD_W-1:0] lo_bound [3];
		logic signed [FIELD_W-1:0] hi_bound [3];
		logic [DSQ_W-1:0]          spacing_sq;
		logic [LIM_W-1:0]          cap;
		logic signed [FIELD_W-1:0] stored_pts [MAX_POINTS_DEF][3];
		int                        n_stored;
		verdict_t                  awaited_verdicts [$];
		int                        errors;

		function new();
			for (int a = 0; a < 3; a++) begin
				lo_bound[a] = 16'sh8000;
				hi_bound[a] = 16'sh7fff;
			end
			spacing_sq = '0;
			cap = 11'd1024;
			n_stored = 0;
			errors = 0;
		endfunction

		function int pending();
			return awaited_verdicts.size();
		endfunction

		// Mirrors a register write; bits above each register's width are ignored.
		function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_LOW_X: lo_bound[0] = data[FIELD_W-1:0];
				CFG_HIGH_X: hi_bound[0] = data[FIELD_W-1:0];
				CFG_LOW_Y: lo_bound[1] = data[FIELD_W-1:0];
				CFG_HIGH_Y: hi_bound[1] = data[FIELD_W-1:0];
				CFG_LOW_Z: lo_bound[2] = data[FIELD_W-1:0];
				CFG_HIGH_Z: hi_bound[2] = data[FIELD_W-1:0];
				CFG_MIN_DIST_SQ: spacing_sq = data[DSQ_W-1:0];
				CFG_POINT_LIMIT: cap = data[LIM_W-1:0];
				default: ;
			endcase
		endfunction

		// Works out the verdict of one accepted point word and updates the store.
		function void note_point(op_t op, logic signed [FIELD_W-1:0] px,
				logic signed [FIELD_W-1:0] py, logic signed [FIELD_W-1:0] pz);
			verdict_t                  v;
			logic signed [FIELD_W-1:0] c [3];
			bit                        oob;
			bit                        close;
			longint                    d;
			longint                    sum;
			int                        eff_cap;
			c[0] = px;
			c[1] = py;
			c[2] = pz;
			v.status = ST_STORED;
			v.slot = '0;
			oob = 1'b0;
			close = 1'b0;
			eff_cap = (int'(cap) > MAX_POINTS_DEF) ? MAX_POINTS_DEF : int'(cap);
			case (op)
				OP_CLEAR: n_stored = 0;
				OP_SEED, OP_TEST: begin
					if (op == OP_TEST) begin
						for (int a = 0; a < 3; a++)
							if (c[a] < lo_bound[a] || c[a] > hi_bound[a])
								oob = 1'b1;
						// Any stored point strictly closer than the spacing rejects.
						if (!oob)
							for (int i = 0; i < n_stored; i++) begin
								sum = 0;
								for (int a = 0; a < 3; a++) begin
									d = longint'(c[a]) - longint'(stored_pts[i][a]);
									sum += d * d;
								end
								if (sum < longint'({30'd0, spacing_sq}))
									close = 1'b1;
							end
					end
					if (oob)
						v.status = ST_OOB;
					else if (close)
						v.status = ST_TOO_CLOSE;
					else if (n_stored >= eff_cap)
						v.status = ST_LIMIT;
					else begin
						v.slot = SLOT_W'(n_stored);
						for (int a = 0; a < 3; a++)
							stored_pts[n_stored][a] = c[a];
						n_stored++;
					end
				end
				default: ;
			endcase
			v.count = CNT_OUT_W'(n_stored);
			awaited_verdicts = {awaited_verdicts, v};
		endfunction

		// Compares one accepted result word with the oldest awaited verdict.
		function void check_result(logic [1:0] status, logic [CNT_OUT_W-1:0] count,
				logic [SLOT_W-1:0] slot);
			verdict_t v;
			if (awaited_verdicts.size() == 0) begin
				$error("result word with nothing awaited: status %0d point_count %0d slot %0d",
					status, count, slot);
				errors++;
				return;
			end
			v = awaited_verdicts.pop_front();
			if (status !== v.status) begin
				$error("status: expected %0d, actual %0d", v.status, status);
				errors++;
			end
			if (count !== v.count) begin
				$error("point_count: expected %0d, actual %0d", v.count, count);
				errors++;
			end
			if (slot !== v.slot) begin
				$error("slot: expected %0d, actual %0d", v.slot, slot);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	mdpa_point_if  pt_bus ();
	mdpa_result_if res_bus ();
	mdpa_cfg_if    cfg_bus ();

	min_distance_point_acceptor_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.point(pt_bus),
		.result(res_bus),
		.cfg(cfg_bus)
	);

	acceptance_scoreboard sb = new();

	// Sender burst state, the current bounds window and the last point sent.
	int  burst_left = 0;
	bit  steady_send = 1'b0;
	int  win_lo [3];
	int  win_hi [3];
	int  last_pt [3];

	// Receiver stall pattern state.
	int  rx_mode = 0;
	int  rx_run = 0;
	int  rx_tick = 0;

	// Clock: 4 ns period.
	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// Result side: check accepted words, then pick the next ready level.
	always @(posedge clk) begin
		if (res_bus.valid && res_bus.ready)
			sb.check_result(res_bus.status, res_bus.point_count, res_bus.slot);
		if (rx_run == 0) begin
			rx_mode = $urandom_range(0, 3);
			rx_run = $urandom_range(20, 300);
		end
		rx_run--;
		rx_tick++;
		case (rx_mode)
			0: res_bus.ready <= 1'b1;
			1: res_bus.ready <= ($urandom_range(0, 1) == 1);
			2: res_bus.ready <= ((rx_tick % 7) > 2);
			default: res_bus.ready <= ($urandom_range(0, 3) == 0);
		endcase
	end

	// Sends one point word, possibly after a gap that ends a burst.
	task automatic send_point(op_t op, int px, int py, int pz);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 8);
			gap = steady_send ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				pt_bus.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		pt_bus.valid <= 1'b1;
		pt_bus.op <= op;
		pt_bus.coord_x <= FIELD_W'(px);
		pt_bus.coord_y <= FIELD_W'(py);
		pt_bus.coord_z <= FIELD_W'(pz);
		do @(posedge clk); while (!pt_bus.ready);
		sb.note_point(op, FIELD_W'(px), FIELD_W'(py), FIELD_W'(pz));
	endtask

	// Stops sending and waits until every awaited verdict has come back.
	task automatic wait_idle();
		pt_bus.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_cfg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data <= data;
		do @(posedge clk); while (!cfg_bus.ready);
		cfg_bus.valid <= 1'b0;
		sb.write_reg(idx, data);
		@(posedge clk);
	endtask

	// Writes all six bounds; the unused upper data bits carry noise.
	task automatic set_window(int lx, int hx, int ly, int hy, int lz, int hz);
		win_lo[0] = lx;
		win_hi[0] = hx;
		win_lo[1] = ly;
		win_hi[1] = hy;
		win_lo[2] = lz;
		win_hi[2] = hz;
		write_cfg(CFG_LOW_X, {18'($urandom()), 16'(lx)});
		write_cfg(CFG_HIGH_X, {18'($urandom()), 16'(hx)});
		write_cfg(CFG_LOW_Y, {18'($urandom()), 16'(ly)});
		write_cfg(CFG_HIGH_Y, {18'($urandom()), 16'(hy)});
		write_cfg(CFG_LOW_Z, {18'($urandom()), 16'(lz)});
		write_cfg(CFG_HIGH_Z, {18'($urandom()), 16'(hz)});
	endtask

	task automatic set_limit(int lim);
		write_cfg(CFG_POINT_LIMIT, {23'($urandom()), 11'(lim)});
	endtask

	// Picks a random setting: mostly windows of moderate size, sometimes the extremes.
	task automatic random_setting();
		int          kind;
		int          r;
		int          c;
		int          hw;
		int          d;
		int          bad_ax;
		int          lo_v [3];
		int          hi_v [3];
		logic [63:0] r64;
		kind = $urandom_range(0, 9);
		for (int a = 0; a < 3; a++) begin
			if (kind == 0) begin
				lo_v[a] = -32768;
				hi_v[a] = 32767;
			end else begin
				c = int'($urandom_range(0, 65535)) - 32768;
				hw = $urandom_range(0, 3000);
				lo_v[a] = (c - hw < -32768) ? -32768 : c - hw;
				hi_v[a] = (c + hw > 32767) ? 32767 : c + hw;
			end
		end
		// Inverted bounds on one axis.
		if (kind == 1) begin
			bad_ax = $urandom_range(0, 2);
			c = int'($urandom_range(0, 65532)) - 32766;
			lo_v[bad_ax] = c + 1;
			hi_v[bad_ax] = c - 1;
		end
		set_window(lo_v[0], hi_v[0], lo_v[1], hi_v[1], lo_v[2], hi_v[2]);
		r = $urandom_range(0, 9);
		r64 = {$urandom(), $urandom()};
		if (r == 0)
			write_cfg(CFG_MIN_DIST_SQ, 34'd0);
		else if (r == 1)
			write_cfg(CFG_MIN_DIST_SQ, r64[33:0]);
		else if (r == 2)
			write_cfg(CFG_MIN_DIST_SQ, 34'd12884901888);
		else begin
			d = $urandom_range(1, 1500);
			write_cfg(CFG_MIN_DIST_SQ, 34'(d * d));
		end
		r = $urandom_range(0, 9);
		if (r == 0)
			set_limit(0);
		else if (r == 1)
			set_limit(1024);
		else if (r == 2)
			set_limit($urandom_range(1025, 2047));
		else
			set_limit($urandom_range(1, 48));
	endtask

	// One random word: mostly tests of points inside the window or near the last point.
	task automatic random_point_word();
		int  r;
		int  pick;
		op_t op;
		int  c [3];
		r = $urandom_range(0, 99);
		if (r < 72)
			op = OP_TEST;
		else if (r < 90)
			op = OP_SEED;
		else if (r < 96)
			op = OP_CLEAR;
		else
			op = OP_NONE;
		pick = $urandom_range(0, 19);
		for (int a = 0; a < 3; a++) begin
			if (pick < 3 || win_lo[a] > win_hi[a])
				c[a] = int'($urandom_range(0, 65535)) - 32768;
			else if (pick < 7)
				c[a] = last_pt[a] + int'($urandom_range(0, 128)) - 64;
			else if (pick < 9)
				c[a] = ($urandom_range(0, 1) == 1) ? win_hi[a] : win_lo[a];
			else
				c[a] = int'($urandom_range(win_lo[a] + 32768, win_hi[a] + 32768)) - 32768;
		end
		if (op == OP_TEST || op == OP_SEED)
			for (int a = 0; a < 3; a++)
				last_pt[a] = int'(16'(c[a]) ^ 16'h8000) - 32768;
		send_point(op, c[0], c[1], c[2]);
	endtask

	// Run limit, far above the slowest correct run.
	initial begin
		#40_000_000;
		$display("Test completed with failures");
		$finish;
	end

	// Stimulus.
	initial begin
		arst_n <= 1'b0;
		pt_bus.valid <= 1'b0;
		pt_bus.op <= OP_SEED;
		pt_bus.coord_x <= '0;
		pt_bus.coord_y <= '0;
		pt_bus.coord_z <= '0;
		cfg_bus.valid <= 1'b0;
		cfg_bus.index <= CFG_LOW_X;
		cfg_bus.data <= '0;
		for (int a = 0; a < 3; a++) begin
			win_lo[a] = -32768;
			win_hi[a] = 32767;
			last_pt[a] = 0;
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset setting: undefined op on an empty store, extreme coordinates, and a
		// duplicate point that passes because the spacing is zero.
		send_point(OP_NONE, 0, 0, 0);
		send_point(OP_TEST, -32768, 32767, 0);
		send_point(OP_SEED, 32767, -32768, 32767);
		send_point(OP_TEST, -32768, 32767, 0);
		send_point(OP_CLEAR, 0, 0, 0);
		wait_idle();

		// Small window with the third axis held at zero, spacing 25, room for four.
		set_window(-100, 100, -100, 100, 0, 0);
		write_cfg(CFG_MIN_DIST_SQ, 34'd625);
		set_limit(4);
		send_point(OP_TEST, 0, 0, 0);
		send_point(OP_TEST, 100, -100, 0);
		send_point(OP_TEST, 101, 0, 0);
		send_point(OP_TEST, 0, -101, 0);
		send_point(OP_TEST, 0, 0, 1);
		send_point(OP_TEST, 24, 0, 0);
		send_point(OP_TEST, 25, 0, 0);
		send_point(OP_TEST, -32768, 0, 0);
		send_point(OP_SEED, 0, 0, 0);
		send_point(OP_SEED, 200, 200, 5);
		send_point(OP_TEST, 1, 1, 0);
		send_point(OP_TEST, -100, 100, 0);
		send_point(OP_NONE, 7, 7, 7);
		send_point(OP_CLEAR, 0, 0, 0);
		wait_idle();

		// Inverted bounds and a zero limit.
		set_window(10, -10, -32768, 32767, -32768, 32767);
		set_limit(0);
		send_point(OP_TEST, 0, 0, 0);
		send_point(OP_SEED, 1, 2, 3);
		wait_idle();

		// Spacing beyond the largest squared distance: only the first point of the store can ever pass.
		set_window(-32768, 32767, -32768, 32767, -32768, 32767);
		write_cfg(CFG_MIN_DIST_SQ, 34'd12884901888);
		set_limit(2047);
		send_point(OP_TEST, -32768, -32768, -32768);
		send_point(OP_TEST, 32767, 32767, 32767);
		send_point(OP_CLEAR, 0, 0, 0);

		// Random phases with mostly small stores.
		for (int ph = 0; ph < 8; ph++) begin
			wait_idle();
			random_setting();
			steady_send = (ph % 3 == 2);
			for (int i = 0; i < 64; i++) begin
				if (ph == 4 && i == 35)
					wait_idle();
				random_point_word();
			end
		end
		steady_send = 1'b0;

		// Fill part of the store under an oversized limit, then probe it.
		wait_idle();
		set_window(-32768, 32767, -32768, 32767, -32768, 32767);
		write_cfg(CFG_MIN_DIST_SQ, 34'd0);
		set_limit(2047);
		send_point(OP_CLEAR, 0, 0, 0);
		for (int i = 0; i < 32; i++)
			send_point(OP_SEED, int'($urandom_range(0, 65535)) - 32768,
				int'($urandom_range(0, 65535)) - 32768, int'($urandom_range(0, 65535)) - 32768);
		send_point(OP_TEST, 123, -456, 789);
		send_point(OP_SEED, 0, 0, 0);
		send_point(OP_TEST, -5, 5, -5);
		wait_idle();
		write_cfg(CFG_MIN_DIST_SQ, 34'h3_ffff_ffff);
		send_point(OP_TEST, 32767, -32768, 0);
		send_point(OP_TEST, int'($urandom_range(0, 65535)) - 32768, 0, 1);
		wait_idle();
		set_window(0, 0, -32768, 32767, -32768, 32767);
		set_limit(1024);
		send_point(OP_TEST, 5, 0, 0);
		send_point(OP_SEED, 0, 0, 0);
		send_point(OP_CLEAR, 0, 0, 0);

		// Drain and report.
		wait_idle();
		repeat (16) @(posedge clk);
		if (sb.errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
